// ===== rtl/wwa_pkg.sv =====
`timescale 1ns / 1ps
package wwa_pkg;

  localparam int TRIG_FRAC_BITS = 15;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int SIN_W = TRIG_FRAC_BITS + 1;
  localparam int SINS_W = TRIG_FRAC_BITS + 2;
  localparam int TIME_W = 32;
  localparam int SPD_W = 10;
  localparam int HDG_W = 9;
  localparam int ENT_W = TIME_W + 2 * SPD_W + HDG_W;
  localparam logic [SPD_W-1:0] GUST_BAND_LO = 10'd370;
  localparam logic [SPD_W-1:0] GUST_BAND_HI = 10'd380;
  localparam longint unsigned PI_Q40 = 64'd3454217652358;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_GROUP = 2'd1;
  localparam logic [1:0] REG_RECORD = 2'd2;

  typedef logic [SIN_W-1:0] sine_tbl_t [0:90];

  // Q30 product, rounded half up
  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Taylor series in Q30, rounded to the working fraction width
  // divisors are (2n)(2n+1) for n = 1..12
  function automatic sine_tbl_t build_sine();
    sine_tbl_t tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned s;
    longint sum;
    int sh;
    sh = 30 - TRIG_FRAC_BITS;
    for (int k = 0; k <= 90; k++) begin
      x = (longint'(k) * PI_Q40 + 64'd92160) / 64'd184320;
      x2 = mul_q30(x, x);
      term = x;
      sum = longint'(x);
      term = mul_q30(term, x2) / 64'd6;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd20;
      sum = sum + longint'(term);
      term = mul_q30(term, x2) / 64'd42;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd72;
      sum = sum + longint'(term);
      term = mul_q30(term, x2) / 64'd110;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd156;
      sum = sum + longint'(term);
      term = mul_q30(term, x2) / 64'd210;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd272;
      sum = sum + longint'(term);
      term = mul_q30(term, x2) / 64'd342;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd420;
      sum = sum + longint'(term);
      term = mul_q30(term, x2) / 64'd506;
      sum = sum - longint'(term);
      term = mul_q30(term, x2) / 64'd600;
      sum = sum + longint'(term);
      if (sum < 0) sum = 0;
      if (sum > longint'(64'd1 << 30)) sum = longint'(64'd1 << 30);
      s = longint'(sum);
      tbl[k] = SIN_W'((s + (64'd1 << (sh - 1))) >> sh);
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine();

  // sine of d degrees, d below 720
  function automatic logic signed [SINS_W-1:0] sin_q(logic [9:0] d);
    logic [9:0] m;
    logic [9:0] i;
    logic neg;
    logic signed [SINS_W-1:0] v;
    m = (d >= 10'd360) ? d - 10'd360 : d;
    neg = 1'b0;
    if (m <= 10'd90) begin
      i = m;
    end else if (m <= 10'd180) begin
      i = 10'd180 - m;
    end else if (m <= 10'd270) begin
      i = m - 10'd180;
      neg = 1'b1;
    end else begin
      i = 10'd360 - m;
      neg = 1'b1;
    end
    v = signed'({1'b0, SINE_TBL[i[6:0]]});
    return neg ? -v : v;
  endfunction

endpackage

// ===== rtl/wwa_in_if.sv =====
`timescale 1ns / 1ps
interface wwa_in_if;
  logic valid;
  logic ready;
  logic [9:0] speed_tenths;
  logic speed_present;
  logic [9:0] gust_tenths;
  logic gust_present;
  logic [8:0] heading_deg;
  logic heading_present;
  logic [31:0] now_seconds;
  modport source(output valid, speed_tenths, speed_present, gust_tenths, gust_present,
                 heading_deg, heading_present, now_seconds, input ready);
  modport sink(input valid, speed_tenths, speed_present, gust_tenths, gust_present,
               heading_deg, heading_present, now_seconds, output ready);
endinterface

// ===== rtl/wwa_out_if.sv =====
`timescale 1ns / 1ps
interface wwa_out_if;
  logic valid;
  logic ready;
  logic new_record;
  logic [9:0] avg_speed_tenths;
  logic [9:0] max_gust_tenths;
  logic gust_valid;
  logic [8:0] mean_heading_deg;
  logic heading_valid;
  logic [6:0] sample_count;
  modport source(output valid, new_record, avg_speed_tenths, max_gust_tenths, gust_valid,
                 mean_heading_deg, heading_valid, sample_count, input ready);
  modport sink(input valid, new_record, avg_speed_tenths, max_gust_tenths, gust_valid,
               mean_heading_deg, heading_valid, sample_count, output ready);
endinterface

// ===== rtl/wwa_ram.sv =====
`timescale 1ns / 1ps
module wwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/wind_window_averager_top.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req_i   | in  | valid/ready | partial wind reading + time stamp
// res_o   | out | valid/ready | window mean, max gust, bearing, count
// apb     | in  | psel/penable| window, group, record enable
// A partial reading only updates the open sample. A completed sample takes a
// queue walk (one RAM read a cycle), an eviction on a full queue, a check and
// removal per aged-out sample, two 33-step divisions and a bearing search (a
// multiply and a compare per degree); with recording off, only store and age.
// Sample queue lives in a single-port-read RAM; no clearing pass after reset.
// One request in flight; the next is taken while the result waits in res_o.
module wind_window_averager_top #(
  parameter int QUEUE_DEPTH = wwa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wwa_in_if.sink      req_i,
  wwa_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + wwa_pkg::SPD_W;
  localparam int PRD_W = wwa_pkg::SINS_W + 11;
  localparam int VEC_W = PRD_W + CNT_W;
  localparam int BPR_W = VEC_W + wwa_pkg::SINS_W;
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 17;

  typedef enum logic [4:0] {
    S_IDLE, S_FULL_RD, S_FULL_VEC, S_FULL_SUB, S_STORE, S_ADD, S_AGE_RD, S_AGE_CHK,
    S_AGE_SUB, S_POST, S_WALK, S_DIV_AVG, S_DIV_REC, S_MUL_REC, S_BR_INIT, S_BR_MUL,
    S_BR_CMP, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] win_q;
  logic [7:0]  grp_q;
  logic        rec_en_q;

  logic [AW-1:0]    oldest_q;
  logic [CNT_W-1:0] cnt_q;
  logic [9:0]       open_spd_q, open_gst_q;
  logic [8:0]       open_hdg_q;
  logic [2:0]       have_q;
  logic             pending_q;
  logic signed [VEC_W-1:0] east_q, north_q;
  logic [31:0]      next_grp_q, next_rec_q, now_q;
  logic signed [PRD_W-1:0] vec_e_q, vec_n_q;

  logic [CNT_W-1:0] idx_q;
  logic             rd_pend_q;
  logic [SUM_W-1:0] sum_q;
  logic [9:0]       maxg_q;
  logic             gv_q;

  logic [DIV_NW-1:0] dnum_q;
  logic [DIV_DW-1:0] drem_q, dden_q;
  logic [5:0]        dcnt_q;
  logic [9:0]        avg_q;
  logic [48:0]       t_q;

  logic [8:0] br_base_q, head_q;
  logic [6:0] br_k_q;
  logic signed [BPR_W-1:0] p1_q, p2_q;

  logic       res_vld_q, res_nr_q, res_gv_q, res_hv_q;
  logic [9:0] res_avg_q, res_gst_q;
  logic [8:0] res_hdg_q;
  logic [6:0] res_cnt_q;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) s = s - (CNT_W+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

  // RAM
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [wwa_pkg::ENT_W-1:0] ram_wdata, ram_rdata;
  logic [31:0] r_time;
  logic [9:0]  r_spd, r_gst;
  logic [8:0]  r_hdg;

  wwa_ram #(.WIDTH(wwa_pkg::ENT_W), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign {r_time, r_spd, r_gst, r_hdg} = ram_rdata;
  assign ram_we = (state_q == S_STORE);
  assign ram_waddr = wrap_add(oldest_q, cnt_q);
  assign ram_wdata = {now_q, open_spd_q, open_gst_q, open_hdg_q};
  assign ram_raddr = (state_q == S_WALK) ? wrap_add(oldest_q, idx_q) : oldest_q;

  // request side
  logic        acc;
  logic        grp_new;
  logic [32:0] grp_sum;
  logic [2:0]  have_nx;
  logic        pend_nx;
  assign req_i.ready = (state_q == S_IDLE);
  assign acc = req_i.valid && req_i.ready;
  assign grp_new = req_i.now_seconds > next_grp_q;
  assign grp_sum = {1'b0, req_i.now_seconds} + 33'(grp_q);
  assign pend_nx = grp_new || pending_q;
  assign have_nx = (grp_new ? 3'b000 : have_q) |
                   {req_i.heading_present, req_i.gust_present, req_i.speed_present};

  // sample vector
  logic [9:0] src_spd;
  logic [8:0] src_hdg;
  logic signed [PRD_W-1:0] prod_e, prod_n;
  always_comb begin
    src_spd = (state_q == S_STORE) ? open_spd_q : r_spd;
    src_hdg = (state_q == S_STORE) ? open_hdg_q : r_hdg;
    prod_e = PRD_W'(signed'({1'b0, src_spd})) * PRD_W'(wwa_pkg::sin_q({1'b0, src_hdg}));
    prod_n = PRD_W'(signed'({1'b0, src_spd})) *
             PRD_W'(wwa_pkg::sin_q({1'b0, src_hdg} + 10'd90));
  end

  logic [15:0] win_eff;
  logic [31:0] age_lim;
  assign win_eff = (win_q == 16'd0) ? 16'd1 : win_q;
  assign age_lim = now_q - 32'(win_eff);

  // shared restoring divider step
  logic [DIV_DW:0]   div_rs;
  logic              div_ge;
  logic [DIV_DW-1:0] div_rem_nx;
  logic [DIV_NW-1:0] div_num_nx;
  always_comb begin
    div_rs = {drem_q, dnum_q[DIV_NW-1]};
    div_ge = div_rs >= {1'b0, dden_q};
    div_rem_nx = div_ge ? DIV_DW'(div_rs - {1'b0, dden_q}) : div_rs[DIV_DW-1:0];
    div_num_nx = {dnum_q[DIV_NW-2:0], div_ge};
  end

  // bearing cross product at base + k + 1
  logic [9:0] br_ang;
  logic signed [BPR_W-1:0] bp1, bp2;
  logic signed [BPR_W:0] br_diff;
  always_comb begin
    br_ang = 10'(br_base_q) + 10'(br_k_q) + 10'd1;
    bp1 = BPR_W'(east_q) * BPR_W'(wwa_pkg::sin_q(br_ang + 10'd90));
    bp2 = BPR_W'(north_q) * BPR_W'(wwa_pkg::sin_q(br_ang));
    br_diff = (BPR_W+1)'(p1_q) - (BPR_W+1)'(p2_q);
  end

  logic nr, calm, out_free, gust_ok;
  assign nr = now_q > next_rec_q;
  assign calm = !nr && (sum_q < SUM_W'(cnt_q)) && (!gv_q || maxg_q == 10'd0);
  assign out_free = !res_vld_q || res_o.ready;
  assign gust_ok = (r_gst < wwa_pkg::GUST_BAND_LO) || (r_gst > wwa_pkg::GUST_BAND_HI);

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      wwa_pkg::REG_WINDOW: prdata = {16'd0, win_q};
      wwa_pkg::REG_GROUP:  prdata = {24'd0, grp_q};
      wwa_pkg::REG_RECORD: prdata = {31'd0, rec_en_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      win_q <= 16'd600;
      grp_q <= 8'd15;
      rec_en_q <= 1'b1;
      oldest_q <= '0;
      cnt_q <= '0;
      open_spd_q <= '0;
      open_gst_q <= '0;
      open_hdg_q <= '0;
      have_q <= '0;
      pending_q <= 1'b0;
      east_q <= '0;
      north_q <= '0;
      next_grp_q <= '0;
      next_rec_q <= '0;
      now_q <= '0;
      vec_e_q <= '0;
      vec_n_q <= '0;
      idx_q <= '0;
      rd_pend_q <= 1'b0;
      sum_q <= '0;
      maxg_q <= '0;
      gv_q <= 1'b0;
      dnum_q <= '0;
      drem_q <= '0;
      dden_q <= '0;
      dcnt_q <= '0;
      avg_q <= '0;
      t_q <= '0;
      br_base_q <= '0;
      br_k_q <= '0;
      head_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
      res_vld_q <= 1'b0;
      res_nr_q <= 1'b0;
      res_gv_q <= 1'b0;
      res_hv_q <= 1'b0;
      res_avg_q <= '0;
      res_gst_q <= '0;
      res_hdg_q <= '0;
      res_cnt_q <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[3:2])
          wwa_pkg::REG_WINDOW: win_q <= pwdata[15:0];
          wwa_pkg::REG_GROUP:  grp_q <= pwdata[7:0];
          wwa_pkg::REG_RECORD: rec_en_q <= pwdata[0];
          default: ;
        endcase
      end

      if (res_vld_q && res_o.ready) res_vld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (grp_new) begin
              next_grp_q <= grp_sum[32] ? 32'hFFFF_FFFF : grp_sum[31:0];
            end
            if (pend_nx) begin
              if (req_i.speed_present) open_spd_q <= req_i.speed_tenths;
              if (req_i.gust_present) open_gst_q <= req_i.gust_tenths;
              if (req_i.heading_present) open_hdg_q <= req_i.heading_deg;
              have_q <= have_nx;
              pending_q <= 1'b1;
              if (have_nx == 3'b111) begin
                pending_q <= 1'b0;
                now_q <= req_i.now_seconds;
                state_q <= (cnt_q >= CNT_W'(QUEUE_DEPTH)) ? S_FULL_RD : S_STORE;
              end
            end
          end
        end
        S_FULL_RD: state_q <= S_FULL_VEC;
        S_FULL_VEC: begin
          vec_e_q <= prod_e;
          vec_n_q <= prod_n;
          state_q <= S_FULL_SUB;
        end
        S_FULL_SUB: begin
          east_q <= east_q - VEC_W'(vec_e_q);
          north_q <= north_q - VEC_W'(vec_n_q);
          oldest_q <= wrap_add(oldest_q, CNT_W'(1));
          cnt_q <= cnt_q - CNT_W'(1);
          state_q <= S_STORE;
        end
        S_STORE: begin
          vec_e_q <= prod_e;
          vec_n_q <= prod_n;
          cnt_q <= cnt_q + CNT_W'(1);
          state_q <= S_ADD;
        end
        S_ADD: begin
          east_q <= east_q + VEC_W'(vec_e_q);
          north_q <= north_q + VEC_W'(vec_n_q);
          state_q <= (now_q >= 32'(win_eff)) ? S_AGE_RD : S_POST;
        end
        S_AGE_RD: state_q <= (cnt_q == '0) ? S_POST : S_AGE_CHK;
        S_AGE_CHK: begin
          if (r_time < age_lim) begin
            vec_e_q <= prod_e;
            vec_n_q <= prod_n;
            state_q <= S_AGE_SUB;
          end else begin
            state_q <= S_POST;
          end
        end
        S_AGE_SUB: begin
          east_q <= east_q - VEC_W'(vec_e_q);
          north_q <= north_q - VEC_W'(vec_n_q);
          oldest_q <= wrap_add(oldest_q, CNT_W'(1));
          cnt_q <= cnt_q - CNT_W'(1);
          state_q <= S_AGE_RD;
        end
        S_POST: begin
          idx_q <= '0;
          rd_pend_q <= 1'b0;
          sum_q <= '0;
          maxg_q <= '0;
          gv_q <= 1'b0;
          state_q <= rec_en_q ? S_WALK : S_IDLE;
        end
        S_WALK: begin
          if (idx_q < cnt_q) begin
            idx_q <= idx_q + CNT_W'(1);
            rd_pend_q <= 1'b1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q) begin
            sum_q <= sum_q + SUM_W'(r_spd);
            if (gust_ok && (!gv_q || r_gst > maxg_q)) begin
              maxg_q <= r_gst;
              gv_q <= 1'b1;
            end
          end else if (idx_q == cnt_q) begin
            dnum_q <= DIV_NW'({sum_q, 1'b0}) + DIV_NW'(cnt_q);
            dden_q <= DIV_DW'({cnt_q, 1'b0});
            drem_q <= '0;
            dcnt_q <= '0;
            state_q <= S_DIV_AVG;
          end
        end
        S_DIV_AVG: begin
          drem_q <= div_rem_nx;
          dnum_q <= div_num_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(DIV_NW - 1)) begin
            avg_q <= div_num_nx[9:0];
            dnum_q <= {1'b0, now_q};
            dden_q <= DIV_DW'(win_eff);
            drem_q <= '0;
            dcnt_q <= '0;
            state_q <= S_DIV_REC;
          end
        end
        S_DIV_REC: begin
          drem_q <= div_rem_nx;
          dnum_q <= div_num_nx;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'(DIV_NW - 1)) state_q <= S_MUL_REC;
        end
        S_MUL_REC: begin
          t_q <= 49'(33'(dnum_q[31:0]) + 33'd1) * 49'(win_eff);
          state_q <= S_BR_INIT;
        end
        S_BR_INIT: begin
          br_k_q <= '0;
          if (east_q == '0) begin
            head_q <= '0;
            state_q <= S_OUT;
          end else begin
            if (!east_q[VEC_W-1]) begin
              br_base_q <= (!north_q[VEC_W-1] && north_q != '0) ? 9'd0 : 9'd90;
            end else begin
              br_base_q <= north_q[VEC_W-1] ? 9'd180 : 9'd270;
            end
            state_q <= S_BR_MUL;
          end
        end
        S_BR_MUL: begin
          if (br_k_q == 7'd89) begin
            head_q <= br_base_q + 9'(br_k_q);
            state_q <= S_OUT;
          end else begin
            p1_q <= bp1;
            p2_q <= bp2;
            state_q <= S_BR_CMP;
          end
        end
        S_BR_CMP: begin
          if (!br_diff[BPR_W]) begin
            br_k_q <= br_k_q + 7'd1;
            state_q <= S_BR_MUL;
          end else begin
            head_q <= br_base_q + 9'(br_k_q);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_vld_q <= 1'b1;
            res_nr_q <= nr;
            res_avg_q <= calm ? 10'd0 : avg_q;
            res_gst_q <= maxg_q;
            res_gv_q <= gv_q;
            res_hdg_q <= calm ? 9'd0 : head_q;
            res_hv_q <= !calm;
            res_cnt_q <= 7'(cnt_q);
            if (nr) next_rec_q <= (t_q[48:32] != '0) ? 32'hFFFF_FFFF : t_q[31:0];
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.new_record = res_nr_q;
  assign res_o.avg_speed_tenths = res_avg_q;
  assign res_o.max_gust_tenths = res_gst_q;
  assign res_o.gust_valid = res_gv_q;
  assign res_o.mean_heading_deg = res_hdg_q;
  assign res_o.heading_valid = res_hv_q;
  assign res_o.sample_count = res_cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_res_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> res_cnt_q != 7'd0) else $error("result with empty window");
  a_res_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(state_q == S_OUT)) else $error("result outside output step");
`endif

endmodule
